FILE: hw/rtl/kpc_pkg.sv
// Package for the key press classifier.
// Holds the configuration struct, event codes and register map.
// No dependencies.
package kpc_pkg;

	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned KEY_W     = 3;
	localparam int unsigned MS_W      = 16;
	localparam int unsigned TICK_W    = 10;
	localparam int unsigned IDLE_W    = 8;

	typedef enum logic [2:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_LONG      = 3'd1,
		REG_RPT_DELAY = 3'd2,
		REG_RPT_INTV  = 3'd3,
		REG_TICK      = 3'd4,
		REG_IDLE      = 3'd5
	} reg_idx_t;

	localparam logic [MS_W-1:0]   RST_DEBOUNCE  = 16'd50;
	localparam logic [MS_W-1:0]   RST_LONG      = 16'd600;
	localparam logic [MS_W-1:0]   RST_RPT_DELAY = 16'd1200;
	localparam logic [MS_W-1:0]   RST_RPT_INTV  = 16'd200;
	localparam logic [TICK_W-1:0] RST_TICK      = 10'd20;
	localparam logic [IDLE_W-1:0] RST_IDLE      = 8'd0;

	localparam logic [MS_W-1:0] HELD_MAX = 16'hFFFF;

	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_SCAN = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		EV_SHORT  = 2'd0,
		EV_LONG   = 2'd1,
		EV_REPEAT = 2'd2
	} event_t;

	typedef struct packed {
		logic [MS_W-1:0]   min_press;
		logic [MS_W-1:0]   long_thresh;
		logic [MS_W-1:0]   rpt_delay;
		logic [MS_W-1:0]   rpt_gap;
		logic [TICK_W-1:0] tick_ms;
		logic [IDLE_W-1:0] idle_levels;
	} cfg_t;

	typedef struct packed {
		logic   hit;
		event_t ev;
	} res_t;

endpackage

FILE: hw/rtl/key_press_classifier.sv
// Key press classifier: short, long and auto-repeat detection for up to NUM_KEYS keys.
// A request passes through the input register, then the result register; out_stall can hold it.
// Throughput: one request per cycle; in_stall rises only while a result is held by out_stall.
// Per-key state is one read-modify-write of flip-flops, done as the input register advances.
// Reset: asynchronous arst_n clears all key state and loads register defaults; no clear pass.
// Depends on kpc_pkg, kpc_regs, kpc_core.
module key_press_classifier
	import kpc_pkg::*;
#(
	parameter int NUM_KEYS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [KEY_W-1:0]  key,
	input  logic              level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KEY_W-1:0]  key_out,
	output logic [1:0]        event_res
);

	cfg_t             cfg;
	res_t             res;
	logic             valid_s1;
	func_t            func_s1;
	logic [KEY_W-1:0] key_s1;
	logic             level_s1;
	logic             advance;
	logic             step_en;
	logic             out_valid_q;
	logic [KEY_W-1:0] key_out_q;
	event_t           event_q;

	kpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kpc_core #(.NUM_KEYS(NUM_KEYS)) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (step_en),
		.func    (func_s1),
		.key     (key_s1),
		.level   (level_s1),
		.res     (res)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			func_s1  <= func_t'(func);
			key_s1   <= key;
			level_s1 <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= step_en && res.hit;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_out_q <= key_s1;
			event_q   <= res.ev;
		end
	end

	assign out_valid = out_valid_q;
	assign key_out   = key_out_q;
	assign event_res = event_q;

endmodule

FILE: hw/rtl/kpc_regs.sv
// APB configuration registers of the key press classifier.
// Depends on kpc_pkg.
module kpc_regs
	import kpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_press   <= RST_DEBOUNCE;
			cfg_q.long_thresh <= RST_LONG;
			cfg_q.rpt_delay   <= RST_RPT_DELAY;
			cfg_q.rpt_gap     <= RST_RPT_INTV;
			cfg_q.tick_ms     <= RST_TICK;
			cfg_q.idle_levels <= RST_IDLE;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE:  cfg_q.min_press   <= pwdata[MS_W-1:0];
				REG_LONG:      cfg_q.long_thresh <= pwdata[MS_W-1:0];
				REG_RPT_DELAY: cfg_q.rpt_delay   <= pwdata[MS_W-1:0];
				REG_RPT_INTV:  cfg_q.rpt_gap     <= pwdata[MS_W-1:0];
				REG_TICK:      cfg_q.tick_ms     <= pwdata[TICK_W-1:0];
				REG_IDLE:      cfg_q.idle_levels <= pwdata[IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEBOUNCE:  prdata = DATA_W'(cfg_q.min_press);
			REG_LONG:      prdata = DATA_W'(cfg_q.long_thresh);
			REG_RPT_DELAY: prdata = DATA_W'(cfg_q.rpt_delay);
			REG_RPT_INTV:  prdata = DATA_W'(cfg_q.rpt_gap);
			REG_TICK:      prdata = DATA_W'(cfg_q.tick_ms);
			REG_IDLE:      prdata = DATA_W'(cfg_q.idle_levels);
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/kpc_core.sv
// Per-key press state and classification logic.
// Read-modify-write of one key's state per step. Depends on kpc_pkg.
module kpc_core
	import kpc_pkg::*;
#(
	parameter int NUM_KEYS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step_en,
	input  func_t            func,
	input  logic [KEY_W-1:0] key,
	input  logic             level,
	output res_t             res
);

	localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [NUM_KEYS-1:0] armed_q;
	logic [NUM_KEYS-1:0] fired_q;
	logic [MS_W-1:0]     held_q [NUM_KEYS];
	logic [MS_W-1:0]     mark_q [NUM_KEYS];

	logic [KIW-1:0] ki;
	logic           in_range;
	logic           armed;
	logic           fired;
	logic [MS_W-1:0] held;
	logic [MS_W-1:0] mark;
	logic [MS_W:0]   sum;
	logic [MS_W:0]   diff;
	logic           idle;
	logic           repeat_ok;
	logic           is_scan;
	logic           pressed;

	assign ki       = key[KIW-1:0];
	assign in_range = ({1'b0, key} < (KEY_W+1)'(NUM_KEYS));
	assign armed    = armed_q[ki];
	assign fired    = fired_q[ki];
	assign held     = held_q[ki];
	assign mark     = mark_q[ki];
	assign idle     = cfg.idle_levels[key];
	assign is_scan  = (func == FUNC_SCAN);
	assign pressed  = (level != idle);
	assign sum      = {1'b0, held} + (MS_W+1)'(cfg.tick_ms);
	assign diff     = {1'b0, held} - {1'b0, mark};
	// diff[MS_W] set means held < mark
	assign repeat_ok = (held >= cfg.rpt_delay) && !diff[MS_W] &&
		(diff[MS_W-1:0] >= cfg.rpt_gap);

	always_comb begin
		res.hit = 1'b0;
		res.ev  = EV_SHORT;
		if (in_range && is_scan && armed) begin
			if (pressed) begin
				if (repeat_ok) begin
					res.hit = 1'b1;
					res.ev  = EV_REPEAT;
				end
			end else if (!fired) begin
				if (held >= cfg.min_press && held <= cfg.long_thresh) begin
					res.hit = 1'b1;
					res.ev  = EV_SHORT;
				end else if (held >= cfg.long_thresh) begin
					res.hit = 1'b1;
					res.ev  = EV_LONG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			fired_q <= '0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				held_q[i] <= '0;
				mark_q[i] <= '0;
			end
		end else if (step_en && in_range) begin
			if (!is_scan) begin
				if (armed)
					held_q[ki] <= sum[MS_W] ? HELD_MAX : sum[MS_W-1:0];
			end else if (pressed) begin
				if (!armed) begin
					armed_q[ki] <= 1'b1;
				end else if (repeat_ok) begin
					mark_q[ki]  <= held;
					fired_q[ki] <= 1'b1;
				end
			end else if (armed) begin
				armed_q[ki] <= 1'b0;
				fired_q[ki] <= 1'b0;
				held_q[ki]  <= '0;
				mark_q[ki]  <= '0;
			end
		end
	end

endmodule

FILE: hw/rtl/kpc_checker.sv
// Port-level checker for the key press classifier, bound to the top level.
// Depends on kpc_pkg for widths.
module kpc_checker
	import kpc_pkg::*;
#(
	parameter int NUM_KEYS = 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [KEY_W-1:0] key_out,
	input logic [1:0]       event_res
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_out) && $stable(event_res))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_new_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a request two cycles earlier");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, key_out} < (KEY_W+1)'(NUM_KEYS)) && (event_res != 2'd3))
		else $error("result key or event out of range");

endmodule

bind key_press_classifier kpc_checker #(.NUM_KEYS(NUM_KEYS)) u_kpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.key_out   (key_out),
	.event_res (event_res)
);
